>>> rtl/ltqs_pkg.sv
// Shared types and constants for the two-queue thread scheduler.
// Used by ltqs_pick, latency_aware_two_queue_scheduler and the testbench; no dependencies.
package ltqs_pkg;

	localparam int THREADS = 16;
	localparam int PTR_W   = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int ID_W    = 4;
	localparam int CMD_W   = 2;
	localparam int TIME_W  = 64;
	localparam int LAT_W   = 32;

	localparam logic [LAT_W-1:0] LATENCY_RESET = 32'd100000;

	// APB byte address of the latency register
	localparam logic [2:0] ADDR_MISS_LATENCY = 3'd0;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [ID_W-1:0]  tid_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_DEQUEUE = 2'd1,
		CMD_PENDING = 2'd2,
		CMD_SWITCH  = 2'd3
	} cmd_t;

	// queue occupancy seen by the pick logic
	typedef struct packed {
		logic ready_empty;
		logic ready_full;
		logic miss_empty;
		logic miss_full;
	} q_status_t;

	// what one command does to the queues
	typedef struct packed {
		logic picked;
		tid_t thread;
		logic pop_ready;
		logic pop_miss;
		logic push_ready;
		logic push_miss;
		logic full_err;
	} q_action_t;

	function automatic ptr_t next_ptr(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(THREADS - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage

>>> rtl/ltqs_pick.sv
// Pick decision for one scheduler command: expiry test of the miss head
// (65-bit sum) and the resulting pops, pushes and full flag. Uses ltqs_pkg.
module ltqs_pick import ltqs_pkg::*; (
	input  cmd_t              cmd,
	input  q_status_t         status,
	input  tid_t              ready_head_id,
	input  tid_t              miss_head_id,
	input  logic [TIME_W-1:0] miss_head_stamp,
	input  logic [LAT_W-1:0]  miss_latency,
	input  logic [TIME_W-1:0] now,
	output q_action_t         action
);

	logic [TIME_W:0] due;
	logic            expired;
	logic            pending_only;
	logic            miss_full_after;

	// no wrap: a due time past 64 bits never expires
	assign due     = {1'b0, miss_head_stamp} + {(TIME_W + 1 - LAT_W)'(0), miss_latency};
	assign expired = {1'b0, now} > due;
	assign pending_only = (cmd == CMD_PENDING);

	always_comb begin
		action = '0;
		miss_full_after = 1'b0;
		if (cmd == CMD_ENQUEUE) begin
			action.push_ready = !status.ready_full;
			action.full_err   = status.ready_full;
		end else begin
			if (status.miss_empty) begin
				action.pop_ready = !pending_only && !status.ready_empty;
			end else if (expired) begin
				action.pop_miss = 1'b1;
			end else if (!pending_only) begin
				if (!status.ready_empty) begin
					action.pop_ready = 1'b1;
				end else begin
					action.pop_miss = 1'b1;
				end
			end
			action.picked = action.pop_ready || action.pop_miss;
			action.thread = action.pop_miss ? miss_head_id :
				(action.pop_ready ? ready_head_id : '0);
			// a pop from a full miss queue frees the slot for the push
			miss_full_after = status.miss_full && !action.pop_miss;
			if (cmd == CMD_SWITCH && action.picked) begin
				action.push_miss = !miss_full_after;
				action.full_err  = miss_full_after;
			end
		end
	end

endmodule

>>> rtl/latency_aware_two_queue_scheduler.sv
// Latency-aware two-queue thread scheduler, top level. Uses ltqs_pkg and ltqs_pick.
// Holds both queue memories, the pointers, the latency register and the APB port.
//
// Each command is accepted in the idle cycle, while the queue memories read
// both heads; in the next cycle the registered head entries (synchronous read)
// feed the pick decision, the pointers update, a push is written back and the
// result is loaded into the output register. A new command is accepted while
// a finished result still waits in the output register; the decide cycle
// holds only if that register is still full and stalled. Because head reads
// always follow a completed write-back, no forwarding is needed. The ready
// queue keeps thread ids; the miss queue keeps id and 64-bit stall stamp per
// entry. A miss head counts as pending once now > miss_latency + stamp,
// summed to 65 bits so an overflowing sum never expires. miss_latency lives
// at byte address 0 of the APB port (reset 100000) and must be written only
// while the scheduler is idle; the block itself does not enforce this. Queue
// entries have no reset; only queue pointers and full flags are cleared.
module latency_aware_two_queue_scheduler import ltqs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// APB configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// command channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [ID_W-1:0]   thread_id,
	input  logic [ID_W-1:0]   current_thread,
	input  logic [TIME_W-1:0] now,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              picked_valid,
	output logic [ID_W-1:0]   picked_thread,
	output logic              full_error
);

	typedef enum logic {
		ST_IDLE,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		tid_t              id;
		logic [TIME_W-1:0] stamp;
	} miss_entry_t;

	state_t state_q;

	// queue memories
	tid_t        ready_mem [THREADS];
	miss_entry_t miss_mem  [THREADS];
	tid_t        ready_rd_q;
	miss_entry_t miss_rd_q;

	// queue pointers
	ptr_t ready_head_q, ready_tail_q;
	ptr_t miss_head_q, miss_tail_q;
	logic ready_full_q, miss_full_q;

	logic [LAT_W-1:0] miss_latency_q;

	// latched command
	cmd_t              cmd_q;
	tid_t              tid_q;
	tid_t              cur_q;
	logic [TIME_W-1:0] now_q;

	// output register
	logic out_valid_q;
	logic picked_valid_q;
	tid_t picked_thread_q;
	logic full_error_q;

	q_status_t status;
	q_action_t action;
	logic      accept;
	logic      commit;
	logic      cfg_write;
	ptr_t      ready_head_nx, ready_tail_nx;
	ptr_t      miss_head_nx, miss_tail_nx;

	// ---------------- configuration port ----------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr == ADDR_MISS_LATENCY);
	assign prdata    = (paddr == ADDR_MISS_LATENCY) ? miss_latency_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_latency_q <= LATENCY_RESET;
		end else if (cfg_write) begin
			miss_latency_q <= pwdata;
		end
	end

	// ---------------- handshake ----------------
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	// decide cycle completes once the output register can take the result
	assign commit   = (state_q == ST_DECIDE) && !(out_valid_q && out_stall);

	assign out_valid     = out_valid_q;
	assign picked_valid  = picked_valid_q;
	assign picked_thread = picked_thread_q;
	assign full_error    = full_error_q;

	// ---------------- decision ----------------
	assign status.ready_empty = (ready_head_q == ready_tail_q) && !ready_full_q;
	assign status.ready_full  = ready_full_q;
	assign status.miss_empty  = (miss_head_q == miss_tail_q) && !miss_full_q;
	assign status.miss_full   = miss_full_q;

	ltqs_pick u_pick (
		.cmd             (cmd_q),
		.status          (status),
		.ready_head_id   (ready_rd_q),
		.miss_head_id    (miss_rd_q.id),
		.miss_head_stamp (miss_rd_q.stamp),
		.miss_latency    (miss_latency_q),
		.now             (now_q),
		.action          (action)
	);

	assign ready_head_nx = action.pop_ready  ? next_ptr(ready_head_q) : ready_head_q;
	assign ready_tail_nx = action.push_ready ? next_ptr(ready_tail_q) : ready_tail_q;
	assign miss_head_nx  = action.pop_miss   ? next_ptr(miss_head_q)  : miss_head_q;
	assign miss_tail_nx  = action.push_miss  ? next_ptr(miss_tail_q)  : miss_tail_q;

	// ---------------- control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ready_head_q <= '0;
			ready_tail_q <= '0;
			ready_full_q <= 1'b0;
			miss_head_q  <= '0;
			miss_tail_q  <= '0;
			miss_full_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DECIDE;
					end
					if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_DECIDE: begin
					if (commit) begin
						state_q      <= ST_IDLE;
						out_valid_q  <= 1'b1;
						ready_head_q <= ready_head_nx;
						ready_tail_q <= ready_tail_nx;
						miss_head_q  <= miss_head_nx;
						miss_tail_q  <= miss_tail_nx;
						if (action.push_ready) begin
							ready_full_q <= (ready_tail_nx == ready_head_nx);
						end else if (action.pop_ready) begin
							ready_full_q <= 1'b0;
						end
						if (action.push_miss) begin
							miss_full_q <= (miss_tail_nx == miss_head_nx);
						end else if (action.pop_miss) begin
							miss_full_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(cmd);
			tid_q <= thread_id;
			cur_q <= current_thread;
			now_q <= now;
		end
		if (commit) begin
			picked_valid_q  <= action.picked;
			picked_thread_q <= action.thread;
			full_error_q    <= action.full_err;
		end
	end

	// ---------------- queue memories ----------------
	// heads are read every cycle; pointers only move at commit
	always_ff @(posedge clk) begin
		if (commit && action.push_ready) begin
			ready_mem[ready_tail_q] <= tid_q;
		end
		ready_rd_q <= ready_mem[ready_head_q];
	end

	always_ff @(posedge clk) begin
		if (commit && action.push_miss) begin
			miss_mem[miss_tail_q] <= '{id: cur_q, stamp: now_q};
		end
		miss_rd_q <= miss_mem[miss_head_q];
	end

endmodule

>>> tb/tb.sv
// Testbench for latency_aware_two_queue_scheduler: directed and random command streams,
// each result checked against an in-bench model of the ready and miss thread queues.
// Depends on ltqs_pkg and the scheduler RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ltqs_pkg::*;

	localparam logic [TIME_W-1:0] TIME_MAX          = '1;
	localparam logic [LAT_W-1:0]  LAT_MAX           = '1;
	// leave slack before touching config
	localparam int                DRAIN_CYCLES      = 8;

	// one result transaction
	typedef struct packed {
		logic picked_valid;
		tid_t picked_thread;
		logic full_error;
	} pick_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic [CMD_W-1:0]  cmd;
	tid_t              thread_id;
	tid_t              current_thread;
	logic [TIME_W-1:0] now;
	logic              out_valid;
	logic              out_stall;
	logic              picked_valid;
	tid_t              picked_thread;
	logic              full_error;

	// shadow of the scheduler: both circular queues, their pointers and the latency
	tid_t              rq_ids [THREADS];
	ptr_t              rq_head;
	ptr_t              rq_tail;
	logic              rq_full;
	tid_t              mq_ids [THREADS];
	logic [TIME_W-1:0] mq_stamps [THREADS];
	ptr_t              mq_head;
	ptr_t              mq_tail;
	logic              mq_full;
	logic [LAT_W-1:0]  lat_shadow;

	pick_t             pending_picks [$];   // predicted results, oldest first
	int                err_cnt     = 0;
	int                tx_gap_max  = 4;     // sender idle cycles per transaction, 0..max
	int                rx_gap_max  = 4;     // receiver stall cycles per transaction, 0..max
	int                rx_hold     = 0;     // long receiver hold-off, counted down by the sink

	latency_aware_two_queue_scheduler u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.thread_id      (thread_id),
		.current_thread (current_thread),
		.now            (now),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.picked_valid   (picked_valid),
		.picked_thread  (picked_thread),
		.full_error     (full_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case a transaction never completes
	initial begin
		#2_000_000;
		$display("FAIL latency_aware_two_queue_scheduler");
		$finish;
	end

	// ---------------------------------------------------------------- model

	function automatic ptr_t wrap_inc(ptr_t p);
		return (int'(p) == THREADS - 1) ? ptr_t'(0) : ptr_t'(p + 1'b1);
	endfunction

	// A parked thread is due once now exceeds stamp + latency. The sum is kept at
	// 65 bits, so a deadline past the end of the time range never comes due.
	function automatic logic miss_head_due(logic [TIME_W-1:0] t);
		logic [TIME_W:0] deadline;
		deadline = {1'b0, mq_stamps[mq_head]} + {{(TIME_W - LAT_W + 1){1'b0}}, lat_shadow};
		return {1'b0, t} > deadline;
	endfunction

	// Pick order: due miss head, then ready head, then any miss head.
	// With due_only set, only a due miss head may be taken.
	function automatic logic choose_thread(logic [TIME_W-1:0] t, logic due_only,
			output tid_t id);
		logic r_empty;
		logic m_empty;
		logic from_miss;
		r_empty = (rq_head == rq_tail) && !rq_full;
		m_empty = (mq_head == mq_tail) && !mq_full;
		id      = '0;
		if (m_empty && (due_only || r_empty)) begin
			return 1'b0;
		end
		if (!m_empty && miss_head_due(t)) begin
			from_miss = 1'b1;
		end else if (due_only) begin
			return 1'b0;
		end else begin
			from_miss = r_empty;
		end
		if (from_miss) begin
			id      = mq_ids[mq_head];
			mq_head = wrap_inc(mq_head);
			mq_full = 1'b0;
		end else begin
			id      = rq_ids[rq_head];
			rq_head = wrap_inc(rq_head);
			rq_full = 1'b0;
		end
		return 1'b1;
	endfunction

	// applies one command to the shadow queues and returns the result it must produce
	function automatic pick_t compute_pick(cmd_t op, tid_t tid, tid_t cur,
			logic [TIME_W-1:0] t);
		pick_t res;
		tid_t  id;
		res = '0;
		case (op)
			CMD_ENQUEUE: begin
				if (rq_full) begin
					res.full_error = 1'b1;
				end else begin
					rq_ids[rq_tail] = tid;
					rq_tail         = wrap_inc(rq_tail);
					rq_full         = (rq_tail == rq_head);
				end
			end
			CMD_DEQUEUE, CMD_PENDING: begin
				res.picked_valid = choose_thread(t, op == CMD_PENDING, id);
			end
			default: begin
				// switch: the running thread is parked only if something replaced it
				res.picked_valid = choose_thread(t, 1'b0, id);
				if (res.picked_valid) begin
					if (mq_full) begin
						res.full_error = 1'b1;
					end else begin
						mq_ids[mq_tail]    = cur;
						mq_stamps[mq_tail] = t;
						mq_tail            = wrap_inc(mq_tail);
						mq_full            = (mq_tail == mq_head);
					end
				end
			end
		endcase
		if (res.picked_valid) begin
			res.picked_thread = id;
		end
		return res;
	endfunction

	// ---------------------------------------------------------------- drivers

	// Offers one command transaction and records its prediction once accepted.
	// Valid is left high on return; the next call either reuses it or drops it.
	task automatic issue(cmd_t op, tid_t tid, tid_t cur, logic [TIME_W-1:0] t);
		int gap;
		gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		cmd            <= op;
		thread_id      <= tid;
		current_thread <= cur;
		now            <= t;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_picks.push_back(compute_pick(op, tid, cur, t));
	endtask

	// stop offering, wait for every outstanding result, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_picks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write of the latency register: setup cycle, then access until pready
	task automatic write_latency(logic [LAT_W-1:0] val);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_MISS_LATENCY;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		lat_shadow  = val;
	endtask

	// Result sink: after each accepted result it stalls for a drawn number of
	// cycles; a nonzero rx_hold overrides that with one long hold-off.
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else begin
				if (out_valid === 1'b1 && !out_stall) begin
					stall_left = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
				end
				if (stall_left > 0) begin
					stall_left--;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- checker

	function automatic void check_field(string field, logic [ID_W-1:0] want,
			logic [ID_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			err_cnt++;
		end
	endfunction

	// every result transaction is matched against the oldest prediction
	always @(posedge clk) begin
		pick_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && !out_stall) begin
			if (pending_picks.size() == 0) begin
				$error("result transaction with no command outstanding");
				err_cnt++;
			end else begin
				want = pending_picks.pop_front();
				check_field("picked_valid", ID_W'(want.picked_valid), ID_W'(picked_valid));
				check_field("picked_thread", want.picked_thread, picked_thread);
				check_field("full_error", ID_W'(want.full_error), ID_W'(full_error));
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// Empty-queue commands, pick priority and the pending boundary at reset latency.
	task automatic test_directed_picks();
		issue(CMD_DEQUEUE, '0, '0, '0);           // both queues empty
		issue(CMD_PENDING, '0, '0, '0);
		issue(CMD_SWITCH, '0, 4'd9, '0);          // nothing to switch to, nothing parked
		issue(CMD_ENQUEUE, 4'd0, 4'd15, '0);
		issue(CMD_ENQUEUE, 4'd15, 4'd0, '0);
		issue(CMD_ENQUEUE, 4'd5, '0, '0);
		issue(CMD_SWITCH, '0, 4'd15, '0);         // takes ready 0, parks 15 at stamp 0
		issue(CMD_DEQUEUE, '0, '0, 64'd50);       // parked thread not due: ready head wins
		issue(CMD_PENDING, '0, '0, 64'd100000);   // exactly at deadline: still not due
		issue(CMD_PENDING, '0, '0, 64'd100001);   // one past deadline: due
		issue(CMD_SWITCH, '0, 4'd3, TIME_MAX);    // takes ready 5, parks 3 at top stamp
		issue(CMD_DEQUEUE, '0, '0, TIME_MAX);     // deadline overflows; fallback to miss head
	endtask

	// Zero and maximum latency, including a deadline that lands on the top time value.
	task automatic test_latency_edges();
		write_latency('0);
		issue(CMD_ENQUEUE, 4'd7, '0, '0);
		issue(CMD_SWITCH, '0, 4'd9, 64'd10);
		issue(CMD_PENDING, '0, '0, 64'd10);       // zero latency, now equals stamp
		issue(CMD_PENDING, '0, '0, 64'd11);
		write_latency(LAT_MAX);
		issue(CMD_ENQUEUE, 4'd1, '0, '0);
		issue(CMD_SWITCH, '0, 4'd2, TIME_MAX - TIME_W'(LAT_MAX));
		issue(CMD_PENDING, '0, '0, TIME_MAX);     // sum is exactly the top value: not due
		issue(CMD_DEQUEUE, '0, '0, TIME_MAX);
	endtask

	// Sink holds off while the source keeps offering, so the block fills and stalls
	// its input; afterwards the source waits until every result is back.
	task automatic test_backpressure();
		int k;
		tx_gap_max = 0;
		rx_hold    = 60;
		for (k = 0; k < 12; k++) begin
			issue(k[0] ? CMD_DEQUEUE : CMD_ENQUEUE, tid_t'($urandom), tid_t'($urandom),
				{$urandom, $urandom});
		end
		settle();
		tx_gap_max = 4;
	endtask

	// Phases of random traffic. Each phase picks a latency, a starting point on the
	// time line, a command mix that fills, drains or balances the queues, and pacing on/off.
	task automatic test_random_traffic();
		int                phase;
		int                n;
		int                roll;
		int                enq_pct;
		int                sw_pct;
		int                deq_pct;
		cmd_t              op;
		logic [TIME_W-1:0] t;
		logic [LAT_W-1:0]  lat;
		for (phase = 0; phase < 12; phase++) begin
			case (phase % 6)
				0: lat = '0;
				1: lat = LAT_W'($urandom_range(1, 40));
				2: lat = LAT_MAX;
				3: lat = LATENCY_RESET;
				4: lat = $urandom;
				default: lat = LAT_W'($urandom_range(1, 200));
			endcase
			write_latency(lat);
			case ($urandom_range(0, 3))
				0: t = '0;
				1: t = TIME_MAX - TIME_W'($urandom_range(0, 3000));   // near the top
				default: t = {$urandom, $urandom};
			endcase
			// fill mix pushes both queues to full, drain mix empties them
			case ($urandom_range(0, 2))
				0: begin
					enq_pct = 60; sw_pct = 25; deq_pct = 5;
				end
				1: begin
					enq_pct = 15; sw_pct = 20; deq_pct = 35;
				end
				default: begin
					enq_pct = 30; sw_pct = 30; deq_pct = 20;
				end
			endcase
			tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
			rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
			for (n = 0; n < 100; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < enq_pct) begin
					op = CMD_ENQUEUE;
				end else if (roll < enq_pct + sw_pct) begin
					op = CMD_SWITCH;
				end else if (roll < enq_pct + sw_pct + deq_pct) begin
					op = CMD_DEQUEUE;
				end else begin
					op = CMD_PENDING;
				end
				// time mostly creeps forward; sometimes it jumps to the deadline
				// of recent stamps, rarely it lands anywhere
				roll = $urandom_range(0, 31);
				if (roll == 0) begin
					t = {$urandom, $urandom};
				end else if (roll < 4) begin
					t = t + TIME_W'(lat) + TIME_W'($urandom_range(0, 3));
				end else begin
					t = t + TIME_W'($urandom_range(0, 8));
				end
				issue(op, tid_t'($urandom), tid_t'($urandom), t);
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		in_valid       <= 1'b0;
		cmd            <= CMD_ENQUEUE;
		thread_id      <= '0;
		current_thread <= '0;
		now            <= '0;
		// reset view: pointers and full flags clear, entries unwritten
		rq_head    = '0;
		rq_tail    = '0;
		rq_full    = 1'b0;
		mq_head    = '0;
		mq_tail    = '0;
		mq_full    = 1'b0;
		lat_shadow = LATENCY_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_picks();
		test_latency_edges();
		test_backpressure();
		test_random_traffic();
		settle();

		if (err_cnt == 0) begin
			$display("PASS latency_aware_two_queue_scheduler");
		end else begin
			$display("FAIL latency_aware_two_queue_scheduler");
		end
		$finish;
	end

endmodule
